### src/kiss_pkg.sv
package kiss_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned SeedW = 64;
  localparam int unsigned CntW  = 5;

  localparam logic [WordW-1:0] SeedSubst    = 32'd3478596;
  localparam logic [WordW-1:0] LcgMult      = 32'd314527869;
  localparam logic [WordW-1:0] LcgInc       = 32'd1234567;
  localparam logic [WordW-1:0] MwcMult      = 32'd4294584393;
  localparam logic [WordW-1:0] SeedMulXs    = 32'd16807;
  localparam logic [WordW-1:0] SeedMulMwc   = 32'd47628;
  localparam logic [WordW-1:0] SeedMulCarry = 32'd32497;

  // words loaded from the substitute seed, used as reset values
  localparam logic [SeedW-1:0] RstXsFull    = 64'(SeedSubst) * 64'(SeedMulXs);
  localparam logic [SeedW-1:0] RstMwcFull   = 64'(SeedSubst) * 64'(SeedMulMwc);
  localparam logic [SeedW-1:0] RstCarryFull = 64'(SeedSubst) * 64'(SeedMulCarry);
  localparam logic [WordW-1:0] RstLcg       = SeedSubst;
  localparam logic [WordW-1:0] RstXs        = RstXsFull[WordW-1:0];
  localparam logic [WordW-1:0] RstMwc       = RstMwcFull[WordW-1:0];
  localparam logic [WordW-1:0] RstCarry     = RstCarryFull[WordW-1:0];

  localparam logic [CntW-1:0] DivLast = 5'd31;

  typedef enum logic [2:0] {
    MUL_SEED_XS    = 3'd0,
    MUL_SEED_MWC   = 3'd1,
    MUL_SEED_CARRY = 3'd2,
    MUL_LCG        = 3'd3,
    MUL_MWC        = 3'd4
  } mul_sel_e;

  typedef struct packed {
    logic     in_load;
    logic     seed_load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     xs_set;
    logic     mwc_set;
    logic     carry_set;
    logic     lcg_adv;
    logic     mwc_adv;
    logic     sum_load;
    logic     div_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic div_last;
  } status_t;

endpackage

### src/kiss_random_generator_ranged.sv
// KISS random generator with ranged draws. Each accepted item (range_low,
// range_high) returns one result: the raw sum of the congruential, xorshift
// and multiply-with-carry words, that sum modulo (high - low + 1) plus low,
// and an error flag. A valid range goes through the range check, the
// generator advance on the shared 32x32 multiplier, the sum, the bit-serial
// remainder unit and the load of the output register, which waits while the
// output register holds a stalled result; then it is back in idle, the only
// state that takes a new item. An inverted range, or one spanning all 32-bit
// values, returns zeros with the error flag and leaves the generator
// untouched. A seed write loads the congruential word directly and the other
// words through the same multiplier, and stalls the input until they are
// loaded; seed 0 loads as 3478596, which is also the state after reset. A
// finished result waits in the output register while the next item is taken.
module kiss_random_generator_ranged (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [kiss_pkg::WordW-1:0] range_low_i,
  input  logic signed [kiss_pkg::WordW-1:0] range_high_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [kiss_pkg::WordW-1:0]        raw_value_o,
  output logic signed [kiss_pkg::WordW-1:0] ranged_value_o,
  output logic                              range_error_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kiss_pkg::SeedW-1:0]        seed_i
);

  kiss_pkg::cmd_t    cmd;
  kiss_pkg::status_t status;

  kiss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kiss_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .seed_i         (seed_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .raw_value_o    (raw_value_o),
    .ranged_value_o (ranged_value_o),
    .range_error_o  (range_error_o)
  );

endmodule

### src/kiss_dp.sv
module kiss_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kiss_pkg::cmd_t                  cmd_i,
  output kiss_pkg::status_t               status_o,
  input  logic [kiss_pkg::SeedW-1:0]      seed_i,
  input  logic signed [kiss_pkg::WordW-1:0] range_low_i,
  input  logic signed [kiss_pkg::WordW-1:0] range_high_i,
  output logic [kiss_pkg::WordW-1:0]      raw_value_o,
  output logic signed [kiss_pkg::WordW-1:0] ranged_value_o,
  output logic                            range_error_o
);

  function automatic logic [kiss_pkg::WordW-1:0] xs_next(
    input logic [kiss_pkg::WordW-1:0] x
  );
    logic [kiss_pkg::WordW-1:0] t;
    t = x ^ (x << 5);
    t = t ^ (t >> 7);
    t = t ^ (t << 22);
    return t;
  endfunction

  logic [kiss_pkg::WordW-1:0] lcg_q, xs_q, mwc_q, carry_q;
  logic [kiss_pkg::SeedW-1:0] prod_q;
  logic [kiss_pkg::WordW-1:0] lo_q, span_q, raw_q, div_q, rem_q;
  logic                       err_q;
  logic [kiss_pkg::CntW-1:0]  cnt_q;
  logic [kiss_pkg::WordW-1:0] raw_out_q, ranged_out_q;
  logic                       err_out_q;

  logic [kiss_pkg::WordW-1:0] mul_a, mul_b, span_d, seed_word;
  logic                       err_d;
  logic [kiss_pkg::SeedW-1:0] mwc_sum;
  logic [kiss_pkg::WordW:0]   trial;
  logic                       trial_ge;

  assign span_d    = range_high_i - range_low_i + 32'd1;
  assign err_d     = (range_low_i > range_high_i) || (span_d == '0);
  assign seed_word = (seed_i == '0) ? kiss_pkg::SeedSubst : seed_i[kiss_pkg::WordW-1:0];
  assign mwc_sum   = prod_q + {32'd0, carry_q};
  assign trial     = {rem_q, div_q[kiss_pkg::WordW-1]};
  assign trial_ge  = trial >= {1'b0, span_q};

  always_comb begin
    mul_a = lcg_q;
    case (cmd_i.mul_sel)
      kiss_pkg::MUL_SEED_XS:    mul_b = kiss_pkg::SeedMulXs;
      kiss_pkg::MUL_SEED_MWC:   mul_b = kiss_pkg::SeedMulMwc;
      kiss_pkg::MUL_SEED_CARRY: mul_b = kiss_pkg::SeedMulCarry;
      kiss_pkg::MUL_LCG:        mul_b = kiss_pkg::LcgMult;
      kiss_pkg::MUL_MWC: begin
        mul_a = mwc_q;
        mul_b = kiss_pkg::MwcMult;
      end
      default:                  mul_b = kiss_pkg::LcgMult;
    endcase
  end

  // generator words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q   <= kiss_pkg::RstLcg;
      xs_q    <= kiss_pkg::RstXs;
      mwc_q   <= kiss_pkg::RstMwc;
      carry_q <= kiss_pkg::RstCarry;
    end else begin
      if (cmd_i.seed_load) begin
        lcg_q <= seed_word;
      end else if (cmd_i.lcg_adv) begin
        lcg_q <= prod_q[kiss_pkg::WordW-1:0] + kiss_pkg::LcgInc;
      end
      if (cmd_i.xs_set) begin
        xs_q <= prod_q[kiss_pkg::WordW-1:0];
      end else if (cmd_i.lcg_adv) begin
        xs_q <= xs_next(xs_q);
      end
      if (cmd_i.mwc_set) begin
        mwc_q <= prod_q[kiss_pkg::WordW-1:0];
      end else if (cmd_i.mwc_adv) begin
        mwc_q <= mwc_sum[kiss_pkg::WordW-1:0];
      end
      if (cmd_i.carry_set) begin
        carry_q <= prod_q[kiss_pkg::WordW-1:0];
      end else if (cmd_i.mwc_adv) begin
        carry_q <= mwc_sum[kiss_pkg::SeedW-1:kiss_pkg::WordW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.in_load) begin
        err_q <= err_d;
      end
      if (cmd_i.sum_load) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= 64'(mul_a) * 64'(mul_b);
    end
    if (cmd_i.in_load) begin
      lo_q   <= range_low_i;
      span_q <= span_d;
    end
    if (cmd_i.sum_load) begin
      raw_q <= lcg_q + xs_q + mwc_q;
      div_q <= lcg_q + xs_q + mwc_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      // restoring remainder, one dividend bit per cycle
      div_q <= {div_q[kiss_pkg::WordW-2:0], 1'b0};
      rem_q <= trial_ge ? 32'(trial - {1'b0, span_q}) : trial[kiss_pkg::WordW-1:0];
    end
    if (cmd_i.out_load) begin
      raw_out_q    <= err_q ? '0 : raw_q;
      ranged_out_q <= err_q ? '0 : rem_q + lo_q;
      err_out_q    <= err_q;
    end
  end

  assign status_o.err      = err_q;
  assign status_o.div_last = (cnt_q == kiss_pkg::DivLast);
  assign raw_value_o       = raw_out_q;
  assign ranged_value_o    = ranged_out_q;
  assign range_error_o     = err_out_q;

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && !err_q |-> rem_q < span_q)
    else $error("remainder not below span at result load");

  a_div_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> !err_q)
    else $error("remainder step on a bad range");

  a_err_zeros: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && err_q |=>
      range_error_o && raw_value_o == '0 && ranged_value_o == '0)
    else $error("bad range result not zeroed");

endmodule

### src/kiss_ctrl.sv
module kiss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  kiss_pkg::status_t status_i,
  output kiss_pkg::cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE       = 11'b000_0000_0001,
    S_SEED_XS    = 11'b000_0000_0010,
    S_SEED_MWC   = 11'b000_0000_0100,
    S_SEED_CARRY = 11'b000_0000_1000,
    S_SEED_FIN   = 11'b000_0001_0000,
    S_CHECK      = 11'b000_0010_0000,
    S_ADV_LCG    = 11'b000_0100_0000,
    S_ADV_MWC    = 11'b000_1000_0000,
    S_SUM        = 11'b001_0000_0000,
    S_DIV        = 11'b010_0000_0000,
    S_FIN        = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, in_xfer, cfg_xfer;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = kiss_pkg::MUL_LCG;
    case (state_q)
      S_IDLE: begin
        if (cfg_xfer) begin
          cmd_o.seed_load = 1'b1;
          state_d = S_SEED_XS;
        end else if (in_xfer) begin
          cmd_o.in_load = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_SEED_XS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = kiss_pkg::MUL_SEED_XS;
        state_d = S_SEED_MWC;
      end
      S_SEED_MWC: begin
        cmd_o.xs_set  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = kiss_pkg::MUL_SEED_MWC;
        state_d = S_SEED_CARRY;
      end
      S_SEED_CARRY: begin
        cmd_o.mwc_set = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = kiss_pkg::MUL_SEED_CARRY;
        state_d = S_SEED_FIN;
      end
      S_SEED_FIN: begin
        cmd_o.carry_set = 1'b1;
        state_d = S_IDLE;
      end
      S_CHECK: begin
        // bad range skips the advance entirely
        if (status_i.err) begin
          state_d = S_FIN;
        end else begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = kiss_pkg::MUL_LCG;
          state_d = S_ADV_LCG;
        end
      end
      S_ADV_LCG: begin
        cmd_o.lcg_adv = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = kiss_pkg::MUL_MWC;
        state_d = S_ADV_MWC;
      end
      S_ADV_MWC: begin
        cmd_o.mwc_adv = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_load = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_CHECK)
    else $error("accepted draw did not enter range check");

  a_err_no_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK && status_i.err |=> state_q == S_FIN)
    else $error("bad range did not skip the advance");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && out_free |=> out_valid_q && state_q == S_IDLE)
    else $error("finished draw not placed in output register");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && status_i.div_last |=> state_q == S_FIN)
    else $error("remainder loop ran past its last step");

endmodule
